>>> rtl/lom_pkg.sv
package lom_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    typedef enum logic [1:0] {
        PH_MATCH,
        PH_CANCEL,
        PH_FINAL
    } t_phase;

    localparam logic       CMD_SUBMIT = 1'b0;
    localparam logic       CMD_CANCEL = 1'b1;
    localparam logic       KIND_TRADE  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [2:0] STS_FILLED    = 3'd0;
    localparam logic [2:0] STS_RESTED    = 3'd1;
    localparam logic [2:0] STS_REJECTED  = 3'd2;
    localparam logic [2:0] STS_DROPPED   = 3'd3;
    localparam logic [2:0] STS_CANCELLED = 3'd4;
    localparam logic [2:0] STS_NOT_FOUND = 3'd5;

    // one resting order as held in the order store
    typedef struct packed {
        logic        side;
        logic [3:0]  symbol;
        logic [31:0] id;
        logic [31:0] price;
        logic [30:0] qty;
        logic [31:0] arrival;
    } t_entry;

endpackage

>>> rtl/lom_ram.sv
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/limit_order_matcher_unit.sv
// Channel  | Direction | Handshake              | Word
// command  | in        | i_start, o_busy        | i_cmd .. i_quantity
// result   | out       | o_valid (one cycle)    | o_kind .. o_last
//
// Each pass reads the order store one slot per cycle through its single read
// port: a scan over all slots, then one decide state. A valid submit takes one
// pass per fill, one pass that finds no further cross and one pass for the final
// book report; a cancel takes two passes (one when its symbol is out of range)
// and a rejected submit one. A new command is taken only while o_busy is low.
// Synchronous active-low reset clears state, valid bits and all three counters.
// The result receiver cannot stall; each result word shows for one cycle.
module limit_order_matcher_unit
    import lom_pkg::*;
#(
    parameter int ORDER_SLOTS  = 32,
    parameter int SYMBOL_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cmd,
    input  logic        i_is_buy,
    input  logic [3:0]  i_symbol,
    input  logic [31:0] i_order_id,
    input  logic [31:0] i_price,
    input  logic [30:0] i_quantity,
    output logic        o_valid,
    output logic        o_kind,
    output logic [31:0] o_trade_price,
    output logic [30:0] o_trade_qty,
    output logic [31:0] o_buyer_id,
    output logic [31:0] o_seller_id,
    output logic [31:0] o_trade_number,
    output logic [2:0]  o_status,
    output logic [30:0] o_remaining_qty,
    output logic [31:0] o_best_bid,
    output logic [31:0] o_best_ask,
    output logic        o_last
);

    localparam int AW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam int EW = $bits(t_entry);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [ORDER_SLOTS-1:0] r_valid, n_valid;
    logic [31:0] r_arr_cnt, n_arr_cnt;
    logic [31:0] r_trd_cnt, n_trd_cnt;
    logic [CW-1:0] r_cnt, n_cnt;

    // latched command
    logic        r_buy, r_sym_ok;
    logic [3:0]  r_sym;
    logic [31:0] r_id, r_px;
    logic [30:0] r_rem, n_rem;
    logic [2:0]  r_sts, n_sts;

    // best-entry trackers, bid and ask
    logic          r_bh, n_bh, r_ah, n_ah;
    logic [AW-1:0] r_bidx, n_bidx, r_aidx, n_aidx;
    logic [31:0]   r_bp, n_bp, r_ap, n_ap;
    logic [31:0]   r_barr, n_barr, r_aarr, n_aarr;
    logic [30:0]   r_bq, n_bq, r_aq, n_aq;
    logic [31:0]   r_bid, n_bid, r_aid, n_aid;

    // result word
    logic        r_ov, n_ov, r_kind, n_kind, r_last, n_last;
    logic [31:0] r_tp, n_tp, r_buyer, n_buyer, r_seller, n_seller, r_tn, n_tn;
    logic [31:0] r_bb, n_bb, r_ba, n_ba;
    logic [30:0] r_tq, n_tq, r_orem, n_orem;
    logic [2:0]  r_osts, n_osts;

    // store port
    logic          we;
    logic [AW-1:0] waddr, raddr, pidx, free_idx;
    t_entry        wdata, rent;
    logic [EW-1:0] rdata;
    logic          free_hit;

    lom_ram #(.WIDTH(EW), .DEPTH(ORDER_SLOTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rent  = t_entry'(rdata);
    assign raddr = r_cnt[AW-1:0];
    assign pidx  = AW'(r_cnt - CW'(1));

    // find the lowest free slot
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int k = ORDER_SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_hit = 1'b1;
                free_idx = AW'(k);
            end
        end
    end

    logic        cand, cand_b_ahead, cand_a_ahead;
    logic [31:0] cand_age, bage, aage;
    logic        opp_hit, crosses;
    logic [31:0] opp_p, opp_arr, opp_id;
    logic [30:0] opp_q, fill, left;
    logic [AW-1:0] opp_idx;

    always_comb begin
        cand_age = r_arr_cnt - rent.arrival;
        bage     = r_arr_cnt - r_barr;
        aage     = r_arr_cnt - r_aarr;
        cand = (r_cnt != '0) && r_valid[pidx] && (rent.symbol == r_sym)
             && ((r_phase != PH_CANCEL) || (rent.id == r_id && rent.side == r_buy));
        cand_b_ahead = !r_bh || (rent.price > r_bp)
                     || (rent.price == r_bp && cand_age > bage);
        cand_a_ahead = !r_ah || (rent.price < r_ap)
                     || (rent.price == r_ap && cand_age > aage);

        opp_hit = r_buy ? r_ah : r_bh;
        opp_p   = r_buy ? r_ap : r_bp;
        opp_arr = r_buy ? r_aarr : r_barr;
        opp_q   = r_buy ? r_aq : r_bq;
        opp_id  = r_buy ? r_aid : r_bid;
        opp_idx = r_buy ? r_aidx : r_bidx;
        crosses = r_buy ? (opp_p <= r_px) : (opp_p >= r_px);
        fill    = (r_rem < opp_q) ? r_rem : opp_q;
        left    = opp_q - fill;
    end

    // sequence scans, fills, rest, cancel and report
    always_comb begin
        n_state = r_state;  n_phase = r_phase;
        n_valid = r_valid;  n_arr_cnt = r_arr_cnt; n_trd_cnt = r_trd_cnt;
        n_cnt = r_cnt;      n_rem = r_rem;         n_sts = r_sts;
        n_bh = r_bh; n_bidx = r_bidx; n_bp = r_bp; n_barr = r_barr;
        n_bq = r_bq; n_bid = r_bid;
        n_ah = r_ah; n_aidx = r_aidx; n_ap = r_ap; n_aarr = r_aarr;
        n_aq = r_aq; n_aid = r_aid;
        n_ov = 1'b0; n_kind = r_kind; n_last = r_last;
        n_tp = r_tp; n_tq = r_tq; n_buyer = r_buyer; n_seller = r_seller;
        n_tn = r_tn; n_osts = r_osts; n_orem = r_orem; n_bb = r_bb; n_ba = r_ba;
        we = 1'b0; waddr = opp_idx; wdata = '0;

        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                n_bh  = 1'b0;
                n_ah  = 1'b0;
                if (i_start) begin
                    n_rem   = i_quantity;
                    n_state = ST_SCAN;
                    if (i_cmd == CMD_SUBMIT) begin
                        if (i_order_id == '0 || i_price == '0 || i_quantity == '0
                            || ({5'd0, i_symbol} >= 9'(SYMBOL_COUNT))) begin
                            n_sts   = STS_REJECTED;
                            n_phase = PH_FINAL;
                        end else begin
                            n_phase = PH_MATCH;
                        end
                    end else begin
                        n_rem   = '0;
                        n_sts   = STS_NOT_FOUND;
                        n_phase = ({5'd0, i_symbol} < 9'(SYMBOL_COUNT)) ? PH_CANCEL
                                                                         : PH_FINAL;
                    end
                end
            end

            ST_SCAN: begin
                // evaluate the slot read last cycle
                if (cand && rent.side && cand_b_ahead) begin
                    n_bh = 1'b1; n_bidx = pidx; n_bp = rent.price;
                    n_barr = rent.arrival; n_bq = rent.qty; n_bid = rent.id;
                end
                if (cand && !rent.side && cand_a_ahead) begin
                    n_ah = 1'b1; n_aidx = pidx; n_ap = rent.price;
                    n_aarr = rent.arrival; n_aq = rent.qty; n_aid = rent.id;
                end
                if (r_cnt == CW'(ORDER_SLOTS)) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            ST_DECIDE: begin
                n_cnt   = '0;
                n_bh    = 1'b0;
                n_ah    = 1'b0;
                n_state = ST_SCAN;
                case (r_phase)
                    PH_MATCH: begin
                        if (r_rem != '0 && opp_hit && crosses) begin
                            // fill against the best resting entry
                            n_ov = 1'b1; n_kind = KIND_TRADE; n_last = 1'b0;
                            n_tp = opp_p; n_tq = fill;
                            n_buyer  = r_buy ? r_id : opp_id;
                            n_seller = r_buy ? opp_id : r_id;
                            n_tn = r_trd_cnt; n_osts = STS_FILLED;
                            n_orem = r_rem - fill; n_bb = '0; n_ba = '0;
                            n_trd_cnt = r_trd_cnt + 32'd1;
                            n_rem = r_rem - fill;
                            if (left == '0) begin
                                n_valid[opp_idx] = 1'b0;
                            end else begin
                                we    = 1'b1;
                                waddr = opp_idx;
                                wdata = '{side: !r_buy, symbol: r_sym, id: opp_id,
                                          price: opp_p, qty: left, arrival: opp_arr};
                            end
                        end else begin
                            n_phase = PH_FINAL;
                            if (r_rem == '0) begin
                                n_sts = STS_FILLED;
                            end else if (free_hit) begin
                                // rest the remainder
                                we    = 1'b1;
                                waddr = free_idx;
                                wdata = '{side: r_buy, symbol: r_sym, id: r_id,
                                          price: r_px, qty: r_rem, arrival: r_arr_cnt};
                                n_valid[free_idx] = 1'b1;
                                n_arr_cnt = r_arr_cnt + 32'd1;
                                n_sts = STS_RESTED;
                            end else begin
                                n_sts = STS_DROPPED;
                            end
                        end
                    end
                    PH_CANCEL: begin
                        n_phase = PH_FINAL;
                        if (r_buy ? r_bh : r_ah) begin
                            n_valid[r_buy ? r_bidx : r_aidx] = 1'b0;
                            n_rem = r_buy ? r_bq : r_aq;
                            n_sts = STS_CANCELLED;
                        end
                    end
                    default: begin
                        // report the final status
                        n_state = ST_IDLE;
                        n_ov = 1'b1; n_kind = KIND_STATUS; n_last = 1'b1;
                        n_tp = '0; n_tq = '0; n_buyer = '0; n_seller = '0;
                        n_tn = r_trd_cnt; n_osts = r_sts; n_orem = r_rem;
                        n_bb = (r_sym_ok && r_bh) ? r_bp : '0;
                        n_ba = (r_sym_ok && r_ah) ? r_ap : '0;
                    end
                endcase
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_FINAL;
            r_valid   <= '0;
            r_arr_cnt <= '0;
            r_trd_cnt <= '0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
            r_bh      <= 1'b0;
            r_ah      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_valid   <= n_valid;
            r_arr_cnt <= n_arr_cnt;
            r_trd_cnt <= n_trd_cnt;
            r_cnt     <= n_cnt;
            r_ov      <= n_ov;
            r_bh      <= n_bh;
            r_ah      <= n_ah;
        end
    end

    // hold payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_buy    <= i_is_buy;
            r_sym    <= i_symbol;
            r_sym_ok <= ({5'd0, i_symbol} < 9'(SYMBOL_COUNT));
            r_id     <= i_order_id;
            r_px     <= i_price;
        end
        r_rem <= n_rem;  r_sts <= n_sts;
        r_bidx <= n_bidx; r_bp <= n_bp; r_barr <= n_barr; r_bq <= n_bq; r_bid <= n_bid;
        r_aidx <= n_aidx; r_ap <= n_ap; r_aarr <= n_aarr; r_aq <= n_aq; r_aid <= n_aid;
        r_kind <= n_kind; r_last <= n_last; r_tp <= n_tp; r_tq <= n_tq;
        r_buyer <= n_buyer; r_seller <= n_seller; r_tn <= n_tn;
        r_osts <= n_osts; r_orem <= n_orem; r_bb <= n_bb; r_ba <= n_ba;
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_valid         = r_ov;
    assign o_kind          = r_kind;
    assign o_trade_price   = r_tp;
    assign o_trade_qty     = r_tq;
    assign o_buyer_id      = r_buyer;
    assign o_seller_id     = r_seller;
    assign o_trade_number  = r_tn;
    assign o_status        = r_osts;
    assign o_remaining_qty = r_orem;
    assign o_best_bid      = r_bb;
    assign o_best_ask      = r_ba;
    assign o_last          = r_last;

endmodule
